FILE: hw/rtl/tpd_pkg.sv
// ----------------------------------------------------------------------------
// Track point decimator package
// Shared constants, codes, status struct and fixed-point helper functions.
// ----------------------------------------------------------------------------
package tpd_pkg;

    localparam int HISTORY_DEPTH = 4096;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
    localparam int COUNT_W       = $clog2(HISTORY_DEPTH + 1);

    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DVD_W  = 34;
    localparam int DVS_W  = 7;

    localparam int HORNER_STEPS = 5;

    localparam logic [MUL_W-1:0] RADIUS_CM   = 33'd637100000;
    localparam logic [MUL_W-1:0] ONE_Q29     = 33'd536870912;
    localparam logic [MUL_W-1:0] PI_MAG      = 33'd1686629713;
    localparam logic [MUL_W-1:0] HALF_PI_MAG = 33'd843314856;

    localparam logic signed [34:0] PI_Q29     = 35'sd1686629713;
    localparam logic signed [34:0] TWO_PI_Q29 = 35'sd3373259426;

    localparam logic [1:0] REG_MIN_DIST = 2'd0;
    localparam logic [1:0] REG_MIN_MOVE = 2'd1;
    localparam logic [1:0] REG_MAX_INT  = 2'd2;
    localparam logic [1:0] REG_JUMP     = 2'd3;

    typedef enum logic [1:0] {
        EV_IGNORED  = 2'd0,
        EV_RESTART  = 2'd1,
        EV_TRACKED  = 2'd2,
        EV_RECORDED = 2'd3
    } event_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    function automatic logic [DVS_W-1:0] horner_div(input logic [2:0] idx);
        logic [DVS_W-1:0] k;
        case (idx)
            3'd0:    k = 7'd90;
            3'd1:    k = 7'd56;
            3'd2:    k = 7'd30;
            3'd3:    k = 7'd12;
            default: k = 7'd2;
        endcase
        return k;
    endfunction

    // reduce into [-pi, pi); inputs never lie more than one turn outside
    function automatic logic [32:0] wrap_pi(input logic [32:0] v);
        logic signed [34:0] w;
        logic signed [34:0] r;
        w = $signed({{2{v[32]}}, v});
        if (w < -PI_Q29)
            r = w + TWO_PI_Q29;
        else if (w >= PI_Q29)
            r = w - TWO_PI_Q29;
        else
            r = w;
        return r[32:0];
    endfunction

    function automatic logic [MUL_W-1:0] mag33(input logic [32:0] v);
        return v[32] ? (~v + 33'd1) : v;
    endfunction

    function automatic logic [31:0] sat32(input logic [36:0] m, input logic neg);
        logic [36:0] mn;
        logic [31:0] r;
        mn = ~m + 37'd1;
        if (!neg)
            r = (m > 37'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        else
            r = (m > 37'h8000_0000) ? 32'h8000_0000 : mn[31:0];
        return r;
    endfunction

endpackage

FILE: hw/rtl/tpd_mul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tpd_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tpd_pkg::MUL_W-1:0]   a,
    input  logic [tpd_pkg::MUL_W-1:0]   b,
    output logic [tpd_pkg::PROD_W-1:0]  prod,
    output tpd_pkg::unit_sts_t          sts
);
    import tpd_pkg::*;

    localparam int CNT_W = $clog2(MUL_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [MUL_W-1:0] a_reg;
    logic [MUL_W-1:0] hi_reg;
    logic [MUL_W-1:0] lo_reg;
    logic [MUL_W:0]   sum;

    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(MUL_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[MUL_W:1];
            lo_reg <= {sum[0], lo_reg[MUL_W-1:1]};
        end
    end

    assign prod     = {hi_reg, lo_reg};
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

FILE: hw/rtl/tpd_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle, narrow divisor.
// ----------------------------------------------------------------------------
module tpd_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tpd_pkg::DVD_W-1:0]  dividend,
    input  logic [tpd_pkg::DVS_W-1:0]  divisor,
    output logic [tpd_pkg::DVD_W-1:0]  quotient,
    output tpd_pkg::unit_sts_t         sts
);
    import tpd_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             ge;

    assign rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge      = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(DVD_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            dvd_reg <= {dvd_reg[DVD_W-2:0], ge};
        end
    end

    assign quotient = dvd_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

FILE: hw/rtl/track_point_decimator.sv
// ----------------------------------------------------------------------------
// Track point decimator
// Projects lat/lon samples onto a local north/east plane and decides
// which points enter the history ring.
// ----------------------------------------------------------------------------
// Steps, accepting edge to out_valid: ignored word goes through DECIDE and OUT;
//   tracked/recorded word runs 10 serial multiplies; restart on first sample or
//   time reversal runs the cosine (1 multiply + 5 multiply/divide pairs);
//   restart after a jump check runs 6 multiplies, then the cosine. One word in flight at a time; the next
//   word is taken the cycle after the result loads. Rate is set by the
//   1 bit/cycle multiplier and divider and by out_stall. Reset: async active low; defaults, no origin.
module track_point_decimator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         sample_ok,
    input  logic [39:0]  time_ms,
    input  logic [31:0]  latitude,
    input  logic [31:0]  longitude,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [1:0]   event_res,
    output logic [31:0]  north_cm,
    output logic [31:0]  east_cm,
    output logic [tpd_pkg::SLOT_W-1:0]  slot,
    output logic [tpd_pkg::COUNT_W-1:0] point_count,
    output logic         dropped_oldest
);
    import tpd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECIDE, ST_NORTH, ST_EAST1, ST_EAST2,
        ST_JUMP_N, ST_JUMP_E, ST_JUMP_T, ST_REC_N, ST_REC_E, ST_REC_D, ST_REC_I,
        ST_COS_SQ, ST_COS_MUL, ST_COS_DIV, ST_COS_END, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic [19:0] min_dist_reg, min_dist_next;
    logic [19:0] min_move_reg, min_move_next;
    logic [19:0] max_int_reg, max_int_next;
    logic [30:0] jump_reg, jump_next;

    logic         started_reg, started_next;
    logic [31:0]  org_lat_reg, org_lat_next;
    logic [31:0]  org_lon_reg, org_lon_next;
    logic [16:0]  org_cos_reg, org_cos_next;
    logic [31:0]  cur_n_reg, cur_n_next;
    logic [31:0]  cur_e_reg, cur_e_next;
    logic [39:0]  last_t_reg, last_t_next;
    logic [39:0]  last_rec_t_reg, last_rec_t_next;
    logic [31:0]  rec_n_reg, rec_n_next;
    logic [31:0]  rec_e_reg, rec_e_next;
    logic [SLOT_W-1:0]  wslot_reg, wslot_next;
    logic [COUNT_W-1:0] held_reg, held_next;

    logic         ok_reg, ok_next;
    logic [39:0]  t_reg, t_next;
    logic [31:0]  lat_reg, lat_next;
    logic [31:0]  lon_reg, lon_next;

    logic [31:0]  n_reg, n_next;
    logic [31:0]  e_reg, e_next;
    logic         neg_reg, neg_next;
    logic [64:0]  acc_reg, acc_next;
    logic         due_reg, due_next;
    logic [MUL_W-1:0] y_reg, y_next;
    logic [32:0]  tt_reg, tt_next;
    logic [2:0]   k_reg, k_next;
    logic         cneg_reg, cneg_next;

    event_t            res_ev_reg, res_ev_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              res_drop_reg, res_drop_next;

    logic              mul_start_reg, mul_start_next;
    logic [MUL_W-1:0]  mul_a_reg, mul_a_next;
    logic [MUL_W-1:0]  mul_b_reg, mul_b_next;
    logic              div_start_reg, div_start_next;
    logic [DVD_W-1:0]  div_dvd_reg, div_dvd_next;
    logic [DVS_W-1:0]  div_dvs_reg, div_dvs_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         ev_out_reg, ev_out_next;
    logic [31:0]        north_reg, north_next;
    logic [31:0]        east_reg, east_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               drop_reg, drop_next;

    logic [PROD_W-1:0] mul_prod;
    logic [DVD_W-1:0]  div_quo;
    unit_sts_t         mul_sts;
    unit_sts_t         div_sts;

    logic [PROD_W-1:0] rnd29, rnd15, rndk;
    logic [32:0]  xw, xa, x_fold;
    logic         x_neg;
    logic [32:0]  dlat, dlon, wlon;
    logic [32:0]  dn_cur, de_cur, dn_rec, de_rec;
    logic [34:0]  t35;
    logic [32:0]  c_rnd;
    logic [16:0]  cm_cl, cos_val;
    logic [39:0]  elapsed;
    logic [SLOT_W-1:0] wslot_inc;

    tpd_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .prod  (mul_prod),
        .sts   (mul_sts)
    );

    tpd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dvd_reg),
        .divisor  (div_dvs_reg),
        .quotient (div_quo),
        .sts      (div_sts)
    );

    assign rnd29 = mul_prod + (PROD_W'(1) << 28);
    assign rnd15 = mul_prod + (PROD_W'(1) << 14);
    assign rndk  = mul_prod + (PROD_W'(horner_div(k_reg)) << 28);

    assign xw     = wrap_pi({lat_reg[31], lat_reg});
    assign xa     = mag33(xw);
    assign x_neg  = xa > HALF_PI_MAG;
    assign x_fold = x_neg ? (PI_MAG - xa) : xa;

    assign dlat   = {lat_reg[31], lat_reg} - {org_lat_reg[31], org_lat_reg};
    assign dlon   = {lon_reg[31], lon_reg} - {org_lon_reg[31], org_lon_reg};
    assign wlon   = wrap_pi(dlon);
    assign dn_cur = {n_reg[31], n_reg} - {cur_n_reg[31], cur_n_reg};
    assign de_cur = {e_reg[31], e_reg} - {cur_e_reg[31], cur_e_reg};
    assign dn_rec = {n_reg[31], n_reg} - {rec_n_reg[31], rec_n_reg};
    assign de_rec = {e_reg[31], e_reg} - {rec_e_reg[31], rec_e_reg};

    assign t35 = tt_reg[32] ? (35'(ONE_Q29) + 35'(div_quo))
                            : (35'(ONE_Q29) - 35'(div_quo));

    assign c_rnd   = mag33(tt_reg) + 33'd8192;
    assign cm_cl   = (c_rnd[32:14] > 19'd32768) ? 17'd32768 : c_rnd[30:14];
    assign cos_val = (tt_reg[32] ^ cneg_reg) ? (~cm_cl + 17'd1) : cm_cl;

    assign elapsed   = t_reg - last_rec_t_reg;
    assign wslot_inc = (wslot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : wslot_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        min_dist_next   = min_dist_reg;
        min_move_next   = min_move_reg;
        max_int_next    = max_int_reg;
        jump_next       = jump_reg;
        started_next    = started_reg;
        org_lat_next    = org_lat_reg;
        org_lon_next    = org_lon_reg;
        org_cos_next    = org_cos_reg;
        cur_n_next      = cur_n_reg;
        cur_e_next      = cur_e_reg;
        last_t_next     = last_t_reg;
        last_rec_t_next = last_rec_t_reg;
        rec_n_next      = rec_n_reg;
        rec_e_next      = rec_e_reg;
        wslot_next      = wslot_reg;
        held_next       = held_reg;
        ok_next         = ok_reg;
        t_next          = t_reg;
        lat_next        = lat_reg;
        lon_next        = lon_reg;
        n_next          = n_reg;
        e_next          = e_reg;
        neg_next        = neg_reg;
        acc_next        = acc_reg;
        due_next        = due_reg;
        y_next          = y_reg;
        tt_next         = tt_reg;
        k_next          = k_reg;
        cneg_next       = cneg_reg;
        res_ev_next     = res_ev_reg;
        res_slot_next   = res_slot_reg;
        res_drop_next   = res_drop_reg;
        mul_start_next  = 1'b0;
        mul_a_next      = mul_a_reg;
        mul_b_next      = mul_b_reg;
        div_start_next  = 1'b0;
        div_dvd_next    = div_dvd_reg;
        div_dvs_next    = div_dvs_reg;
        out_valid_next  = out_valid_reg && out_stall;
        ev_out_next     = ev_out_reg;
        north_next      = north_reg;
        east_next       = east_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        drop_next       = drop_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_DIST: min_dist_next = cfg_data[19:0];
                REG_MIN_MOVE: min_move_next = cfg_data[19:0];
                REG_MAX_INT:  max_int_next  = cfg_data[19:0];
                REG_JUMP:     jump_next     = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ok_next    = sample_ok;
                    t_next     = time_ms;
                    lat_next   = latitude;
                    lon_next   = longitude;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                res_slot_next = '0;
                res_drop_next = 1'b0;
                if (!ok_reg)
                begin
                    res_ev_next = EV_IGNORED;
                    n_next      = '0;
                    e_next      = '0;
                    state_next  = ST_OUT;
                end
                else if (!started_reg || t_reg < last_t_reg)
                begin
                    mul_a_next     = x_fold;
                    mul_b_next     = x_fold;
                    mul_start_next = 1'b1;
                    cneg_next      = x_neg;
                    state_next     = ST_COS_SQ;
                end
                else
                begin
                    mul_a_next     = mag33(dlat);
                    mul_b_next     = RADIUS_CM;
                    mul_start_next = 1'b1;
                    neg_next       = dlat[32];
                    state_next     = ST_NORTH;
                end
            end
            ST_NORTH:
            begin
                if (mul_sts.done)
                begin
                    n_next         = sat32(rnd29[65:29], neg_reg);
                    mul_a_next     = mag33(wlon);
                    mul_b_next     = mag33({{16{org_cos_reg[16]}}, org_cos_reg});
                    mul_start_next = 1'b1;
                    neg_next       = wlon[32] ^ org_cos_reg[16];
                    state_next     = ST_EAST1;
                end
            end
            ST_EAST1:
            begin
                if (mul_sts.done)
                begin
                    mul_a_next     = rnd15[47:15];
                    mul_b_next     = RADIUS_CM;
                    mul_start_next = 1'b1;
                    state_next     = ST_EAST2;
                end
            end
            ST_EAST2:
            begin
                if (mul_sts.done)
                begin
                    e_next         = sat32(rnd29[65:29], neg_reg);
                    mul_a_next     = mag33(dn_cur);
                    mul_b_next     = mag33(dn_cur);
                    mul_start_next = 1'b1;
                    state_next     = ST_JUMP_N;
                end
            end
            ST_JUMP_N:
            begin
                if (mul_sts.done)
                begin
                    acc_next       = mul_prod[64:0];
                    mul_a_next     = mag33(de_cur);
                    mul_b_next     = mag33(de_cur);
                    mul_start_next = 1'b1;
                    state_next     = ST_JUMP_E;
                end
            end
            ST_JUMP_E:
            begin
                if (mul_sts.done)
                begin
                    acc_next       = acc_reg + mul_prod[64:0];
                    mul_a_next     = MUL_W'(jump_reg);
                    mul_b_next     = MUL_W'(jump_reg);
                    mul_start_next = 1'b1;
                    state_next     = ST_JUMP_T;
                end
            end
            ST_JUMP_T:
            begin
                if (mul_sts.done)
                begin
                    if (acc_reg > mul_prod[64:0])
                    begin
                        mul_a_next     = x_fold;
                        mul_b_next     = x_fold;
                        mul_start_next = 1'b1;
                        cneg_next      = x_neg;
                        state_next     = ST_COS_SQ;
                    end
                    else
                    begin
                        cur_n_next     = n_reg;
                        cur_e_next     = e_reg;
                        last_t_next    = t_reg;
                        mul_a_next     = mag33(dn_rec);
                        mul_b_next     = mag33(dn_rec);
                        mul_start_next = 1'b1;
                        state_next     = ST_REC_N;
                    end
                end
            end
            ST_REC_N:
            begin
                if (mul_sts.done)
                begin
                    acc_next       = mul_prod[64:0];
                    mul_a_next     = mag33(de_rec);
                    mul_b_next     = mag33(de_rec);
                    mul_start_next = 1'b1;
                    state_next     = ST_REC_E;
                end
            end
            ST_REC_E:
            begin
                if (mul_sts.done)
                begin
                    acc_next       = acc_reg + mul_prod[64:0];
                    mul_a_next     = MUL_W'(min_dist_reg);
                    mul_b_next     = MUL_W'(min_dist_reg);
                    mul_start_next = 1'b1;
                    state_next     = ST_REC_D;
                end
            end
            ST_REC_D:
            begin
                if (mul_sts.done)
                begin
                    due_next       = (held_reg == '0) || (acc_reg >= mul_prod[64:0]);
                    mul_a_next     = MUL_W'(min_move_reg);
                    mul_b_next     = MUL_W'(min_move_reg);
                    mul_start_next = 1'b1;
                    state_next     = ST_REC_I;
                end
            end
            ST_REC_I:
            begin
                if (mul_sts.done)
                begin
                    if (due_reg || ((elapsed >= 40'(max_int_reg)) &&
                                    (acc_reg >= mul_prod[64:0])))
                    begin
                        res_ev_next     = EV_RECORDED;
                        res_slot_next   = wslot_reg;
                        wslot_next      = wslot_inc;
                        if (held_reg < COUNT_W'(HISTORY_DEPTH))
                            held_next = held_reg + 1'b1;
                        else
                            res_drop_next = 1'b1;
                        rec_n_next      = n_reg;
                        rec_e_next      = e_reg;
                        last_rec_t_next = t_reg;
                    end
                    else
                    begin
                        res_ev_next = EV_TRACKED;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_COS_SQ:
            begin
                if (mul_sts.done)
                begin
                    y_next         = rnd29[61:29];
                    tt_next        = ONE_Q29;
                    k_next         = '0;
                    mul_a_next     = rnd29[61:29];
                    mul_b_next     = ONE_Q29;
                    mul_start_next = 1'b1;
                    state_next     = ST_COS_MUL;
                end
            end
            ST_COS_MUL:
            begin
                if (mul_sts.done)
                begin
                    div_dvd_next   = rndk[62:29];
                    div_dvs_next   = horner_div(k_reg);
                    div_start_next = 1'b1;
                    state_next     = ST_COS_DIV;
                end
            end
            ST_COS_DIV:
            begin
                if (div_sts.done)
                begin
                    tt_next = t35[32:0];
                    k_next  = k_reg + 1'b1;
                    if (k_reg == 3'(HORNER_STEPS - 1))
                    begin
                        state_next = ST_COS_END;
                    end
                    else
                    begin
                        mul_a_next     = y_reg;
                        mul_b_next     = mag33(t35[32:0]);
                        mul_start_next = 1'b1;
                        state_next     = ST_COS_MUL;
                    end
                end
            end
            ST_COS_END:
            begin
                started_next    = 1'b1;
                org_lat_next    = lat_reg;
                org_lon_next    = lon_reg;
                org_cos_next    = cos_val;
                cur_n_next      = '0;
                cur_e_next      = '0;
                rec_n_next      = '0;
                rec_e_next      = '0;
                last_t_next     = t_reg;
                last_rec_t_next = t_reg;
                wslot_next      = SLOT_W'(1 % HISTORY_DEPTH);
                held_next       = COUNT_W'(1);
                n_next          = '0;
                e_next          = '0;
                res_ev_next     = EV_RESTART;
                res_slot_next   = '0;
                res_drop_next   = 1'b0;
                state_next      = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ev_out_next    = res_ev_reg;
                    north_next     = n_reg;
                    east_next      = e_reg;
                    slot_next      = res_slot_reg;
                    count_next     = held_reg;
                    drop_next      = res_drop_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            min_dist_reg   <= 20'd500;
            min_move_reg   <= 20'd10;
            max_int_reg    <= 20'd1000;
            jump_reg       <= 31'd5000000;
            started_reg    <= 1'b0;
            org_lat_reg    <= '0;
            org_lon_reg    <= '0;
            org_cos_reg    <= '0;
            cur_n_reg      <= '0;
            cur_e_reg      <= '0;
            last_t_reg     <= '0;
            last_rec_t_reg <= '0;
            rec_n_reg      <= '0;
            rec_e_reg      <= '0;
            wslot_reg      <= '0;
            held_reg       <= '0;
            ok_reg         <= 1'b0;
            t_reg          <= '0;
            lat_reg        <= '0;
            lon_reg        <= '0;
            n_reg          <= '0;
            e_reg          <= '0;
            neg_reg        <= 1'b0;
            acc_reg        <= '0;
            due_reg        <= 1'b0;
            y_reg          <= '0;
            tt_reg         <= '0;
            k_reg          <= '0;
            cneg_reg       <= 1'b0;
            res_ev_reg     <= EV_IGNORED;
            res_slot_reg   <= '0;
            res_drop_reg   <= 1'b0;
            mul_start_reg  <= 1'b0;
            mul_a_reg      <= '0;
            mul_b_reg      <= '0;
            div_start_reg  <= 1'b0;
            div_dvd_reg    <= '0;
            div_dvs_reg    <= '0;
            out_valid_reg  <= 1'b0;
            ev_out_reg     <= '0;
            north_reg      <= '0;
            east_reg       <= '0;
            slot_reg       <= '0;
            count_reg      <= '0;
            drop_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            min_dist_reg   <= min_dist_next;
            min_move_reg   <= min_move_next;
            max_int_reg    <= max_int_next;
            jump_reg       <= jump_next;
            started_reg    <= started_next;
            org_lat_reg    <= org_lat_next;
            org_lon_reg    <= org_lon_next;
            org_cos_reg    <= org_cos_next;
            cur_n_reg      <= cur_n_next;
            cur_e_reg      <= cur_e_next;
            last_t_reg     <= last_t_next;
            last_rec_t_reg <= last_rec_t_next;
            rec_n_reg      <= rec_n_next;
            rec_e_reg      <= rec_e_next;
            wslot_reg      <= wslot_next;
            held_reg       <= held_next;
            ok_reg         <= ok_next;
            t_reg          <= t_next;
            lat_reg        <= lat_next;
            lon_reg        <= lon_next;
            n_reg          <= n_next;
            e_reg          <= e_next;
            neg_reg        <= neg_next;
            acc_reg        <= acc_next;
            due_reg        <= due_next;
            y_reg          <= y_next;
            tt_reg         <= tt_next;
            k_reg          <= k_next;
            cneg_reg       <= cneg_next;
            res_ev_reg     <= res_ev_next;
            res_slot_reg   <= res_slot_next;
            res_drop_reg   <= res_drop_next;
            mul_start_reg  <= mul_start_next;
            mul_a_reg      <= mul_a_next;
            mul_b_reg      <= mul_b_next;
            div_start_reg  <= div_start_next;
            div_dvd_reg    <= div_dvd_next;
            div_dvs_reg    <= div_dvs_next;
            out_valid_reg  <= out_valid_next;
            ev_out_reg     <= ev_out_next;
            north_reg      <= north_next;
            east_reg       <= east_next;
            slot_reg       <= slot_next;
            count_reg      <= count_next;
            drop_reg       <= drop_next;
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign event_res      = ev_out_reg;
    assign north_cm       = north_reg;
    assign east_cm        = east_reg;
    assign slot           = slot_reg;
    assign point_count    = count_reg;
    assign dropped_oldest = drop_reg;

endmodule

FILE: hw/rtl/tpd_checker.sv
// ----------------------------------------------------------------------------
// Track point decimator checker
// Port-level properties of the decimator, bound to the top level.
// ----------------------------------------------------------------------------
module tpd_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         in_valid,
    input logic         in_stall,
    input logic         out_valid,
    input logic         out_stall,
    input logic [1:0]   event_res,
    input logic [31:0]  north_cm,
    input logic [31:0]  east_cm,
    input logic [tpd_pkg::SLOT_W-1:0]  slot,
    input logic [tpd_pkg::COUNT_W-1:0] point_count,
    input logic         dropped_oldest
);
    import tpd_pkg::*;

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_res) &&
        $stable(north_cm) && $stable(east_cm) && $stable(point_count))
        else $error("stalled output word changed");

    // one word in flight
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a word is in flight");

    a_restart_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_RESTART |->
        point_count == COUNT_W'(1) && north_cm == '0 && east_cm == '0 && slot == '0)
        else $error("restart word not at origin");

    a_ignored_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_IGNORED || event_res == EV_TRACKED) |->
        slot == '0 && !dropped_oldest)
        else $error("slot or drop flag set without a record");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped_oldest |->
        event_res == EV_RECORDED && point_count == COUNT_W'(HISTORY_DEPTH))
        else $error("drop flag without a full ring");

endmodule

bind track_point_decimator tpd_checker u_tpd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .event_res      (event_res),
    .north_cm       (north_cm),
    .east_cm        (east_cm),
    .slot           (slot),
    .point_count    (point_count),
    .dropped_oldest (dropped_oldest)
);

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Track point decimator testbench
// Directed table, then random track walks with noise under several register
// settings. Result words of typed table rows are checked against the table;
// all others against an in-bench track projection and decimation model.
// ----------------------------------------------------------------------------
module testbench;
    import tpd_pkg::*;

    localparam longint PI_FX     = 64'sd1686629713;
    localparam longint TWO_PI_FX = 64'sd3373259426;
    localparam longint HALF_PI   = 64'sd843314856;
    localparam longint ONE_FX    = 64'sd536870912;
    localparam longint EARTH_CM  = 64'sd637100000;
    localparam int     IDLE_LIMIT = 20000;
    localparam int     EXP_DEPTH  = 16;

    typedef struct {
        event_t      ev;
        logic [31:0] north;
        logic [31:0] east;
        logic [11:0] slot;
        logic [12:0] count;
        logic        drop;
    } track_word_t;

    typedef struct {
        logic        ok;
        logic [39:0] t;
        logic [31:0] lat;
        logic [31:0] lon;
        bit          typed;
        event_t      ev;
        logic [12:0] count;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        sample_ok;
    logic [39:0] time_ms;
    logic [31:0] latitude;
    logic [31:0] longitude;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  event_res;
    logic [31:0] north_cm;
    logic [31:0] east_cm;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] point_count;
    logic        dropped_oldest;

    track_point_decimator uut (.*);

    // model state
    longint unsigned min_dist_cm, min_move_cm, max_int_ms, jump_cm;
    bit              trk_started;
    longint          org_lat, org_lon, org_cos;
    longint          cur_n, cur_e, rec_n, rec_e;
    longint unsigned last_t, last_rec_t;
    int unsigned     next_slot, held;

    // expected words, written by the sender, read by the monitor
    track_word_t exp_words[EXP_DEPTH];
    int          exp_wr = 0;
    int          exp_rd = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          calm;

    // walk cursor
    longint          walk_lat, walk_lon;
    longint unsigned walk_t;
    int              step_span;

    always #5 clk = ~clk;

    function automatic longint rnd_div(longint v, longint d);
        if (v >= 0)
            return (v + d / 2) / d;
        return -((-v + d / 2) / d);
    endfunction

    function automatic longint wrap_angle(longint v);
        longint m;
        m = (v + PI_FX) % TWO_PI_FX;
        if (m < 0)
            m += TWO_PI_FX;
        return m - PI_FX;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint cosine_q15(longint ang);
        longint x, y, t, c;
        longint kdiv[5];
        bit     neg;
        kdiv = '{90, 56, 30, 12, 2};
        neg = 0;
        t = ONE_FX;
        x = wrap_angle(ang);
        if (x < 0)
            x = -x;
        if (x > HALF_PI)
        begin
            x = PI_FX - x;
            neg = 1;
        end
        y = rnd_div(x * x, ONE_FX);
        for (int i = 0; i < 5; i++)
            t = ONE_FX - rnd_div(y * t, ONE_FX * kdiv[i]);
        c = rnd_div(t, 16384);
        if (neg)
            c = -c;
        if (c > 32768)
            c = 32768;
        if (c < -32768)
            c = -32768;
        return c;
    endfunction

    function automatic longint unsigned square_sat(longint d);
        longint unsigned a;
        a = (d < 0) ? -d : d;
        if (a >= 64'd4294967296)
            return '1;
        return a * a;
    endfunction

    function automatic longint unsigned span_sq(longint n1, longint e1,
                                                longint n2, longint e2);
        longint unsigned a, b;
        a = square_sat(n1 - n2);
        b = square_sat(e1 - e2);
        return (a > ~b) ? '1 : a + b;
    endfunction

    function automatic void set_origin(longint unsigned t, longint lat, longint lon);
        trk_started = 1;
        org_lat = lat;
        org_lon = lon;
        org_cos = cosine_q15(lat);
        cur_n = 0;
        cur_e = 0;
        rec_n = 0;
        rec_e = 0;
        last_t = t;
        last_rec_t = t;
        next_slot = 1 % HISTORY_DEPTH;
        held = 1;
    endfunction

    function automatic track_word_t decimate(logic ok, logic [39:0] tin,
                                             logic [31:0] lat_in, logic [31:0] lon_in);
        track_word_t     w;
        longint          lat, lon, n, e, ev;
        longint unsigned t, drec;
        bit              dist_due, int_due;
        t = tin;
        lat = longint'($signed(lat_in));
        lon = longint'($signed(lon_in));
        n = 0;
        e = 0;
        w.ev = EV_IGNORED;
        w.slot = 0;
        w.drop = 0;
        if (!ok)
            ;
        else if (!trk_started || t < last_t)
        begin
            set_origin(t, lat, lon);
            w.ev = EV_RESTART;
        end
        else
        begin
            n = clip32(rnd_div((lat - org_lat) * EARTH_CM, ONE_FX));
            ev = rnd_div(wrap_angle(lon - org_lon) * org_cos, 32768);
            e = clip32(rnd_div(ev * EARTH_CM, ONE_FX));
            if (span_sq(n, e, cur_n, cur_e) > jump_cm * jump_cm)
            begin
                set_origin(t, lat, lon);
                w.ev = EV_RESTART;
                n = 0;
                e = 0;
            end
            else
            begin
                cur_n = n;
                cur_e = e;
                last_t = t;
                drec = span_sq(n, e, rec_n, rec_e);
                dist_due = held == 0 || drec >= min_dist_cm * min_dist_cm;
                int_due = (t - last_rec_t) >= max_int_ms &&
                          drec >= min_move_cm * min_move_cm;
                if (!dist_due && !int_due)
                    w.ev = EV_TRACKED;
                else
                begin
                    w.ev = EV_RECORDED;
                    w.slot = next_slot[11:0];
                    next_slot = (next_slot + 1) % HISTORY_DEPTH;
                    if (held < HISTORY_DEPTH)
                        held++;
                    else
                        w.drop = 1;
                    rec_n = n;
                    rec_e = e;
                    last_rec_t = t;
                end
            end
        end
        w.north = n[31:0];
        w.east = e[31:0];
        w.count = held[12:0];
        return w;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [30:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MIN_DIST: min_dist_cm = val & 20'hFFFFF;
            REG_MIN_MOVE: min_move_cm = val & 20'hFFFFF;
            REG_MAX_INT:  max_int_ms = val & 20'hFFFFF;
            default:      jump_cm = val;
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_word(logic ok, logic [39:0] t, logic [31:0] lat, logic [31:0] lon,
                             bit typed = 0, event_t tev = EV_IGNORED,
                             logic [12:0] tcount = 0);
        int          gap;
        track_word_t w;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_ok <= ok;
        time_ms <= t;
        latitude <= lat;
        longitude <= lon;
        do
            @(posedge clk);
        while (in_stall);
        w = decimate(ok, t, lat, lon);
        if (typed)
        begin
            w.ev = tev;
            w.north = 0;
            w.east = 0;
            w.slot = 0;
            w.count = tcount;
            w.drop = 0;
        end
        exp_words[exp_wr % EXP_DEPTH] = w;
        exp_wr++;
    endtask

    task automatic walk_word();
        int              pick;
        longint unsigned r;
        pick = $urandom_range(0, 99);
        if (pick < 75)
        begin
            walk_lat += $signed($urandom_range(0, 2 * step_span)) - step_span;
            walk_lon += $signed($urandom_range(0, 2 * step_span)) - step_span;
            if (walk_lat > PI_FX || walk_lat < -PI_FX)
                walk_lat = 0;
            if (walk_lon > PI_FX || walk_lon < -PI_FX)
                walk_lon = 0;
            walk_t += $urandom_range(0, 1500);
            send_word(1'b1, walk_t[39:0], walk_lat[31:0], walk_lon[31:0]);
        end
        else if (pick < 82)
        begin
            r = {$urandom, $urandom};
            send_word(1'b0, r[39:0], $urandom, $urandom);
        end
        else if (pick < 87)
        begin
            r = $urandom_range(0, 5000);
            walk_t = (walk_t > r) ? walk_t - r : 0;
            send_word(1'b1, walk_t[39:0], walk_lat[31:0], walk_lon[31:0]);
        end
        else if (pick < 94)
        begin
            walk_lat = longint'($urandom_range(0, 32'(TWO_PI_FX))) - PI_FX;
            walk_lon = longint'($urandom_range(0, 32'(TWO_PI_FX))) - PI_FX;
            walk_t += $urandom_range(0, 3000);
            send_word(1'b1, walk_t[39:0], walk_lat[31:0], walk_lon[31:0]);
        end
        else
        begin
            r = {$urandom, $urandom};
            walk_t = r[39:0];
            send_word(1'b1, walk_t[39:0], $urandom, $urandom);
        end
    endtask

    // result side
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 9);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        track_word_t w;
        if (out_valid && !out_stall)
        begin
            if (exp_wr == exp_rd)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: ev %0d", event_res);
            end
            else
            begin
                w = exp_words[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (event_res !== w.ev || north_cm !== w.north || east_cm !== w.east ||
                    slot !== w.slot || point_count !== w.count ||
                    dropped_oldest !== w.drop)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp ev %0d n %0d e %0d slot %0d cnt %0d drop %0d",
                                 w.ev, $signed(w.north), $signed(w.east), w.slot,
                                 w.count, w.drop);
                        $display("          got ev %0d n %0d e %0d slot %0d cnt %0d drop %0d",
                                 event_res, $signed(north_cm), $signed(east_cm),
                                 slot, point_count, dropped_oldest);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL track_point_decimator");
            $finish;
        end
    end

    initial
    begin
        table_row_t rows[$];
        logic [30:0] regv[4];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MIN_DIST;
        cfg_data = '0;
        in_valid = 1'b0;
        sample_ok = 1'b0;
        time_ms = '0;
        latitude = '0;
        longitude = '0;
        calm = 0;
        min_dist_cm = 500;
        min_move_cm = 10;
        max_int_ms = 1000;
        jump_cm = 5000000;
        trk_started = 0;
        org_lat = 0; org_lon = 0; org_cos = 0;
        cur_n = 0; cur_e = 0; rec_n = 0; rec_e = 0;
        last_t = 0; last_rec_t = 0;
        next_slot = 0; held = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table under reset settings
        rows = '{
            '{1'b0, 40'd0, 32'd0, 32'd0, 1, EV_IGNORED, 13'd0},
            '{1'b1, 40'd1000, 32'd0, 32'd0, 1, EV_RESTART, 13'd1},
            '{1'b1, 40'd1100, 32'd0, 32'd0, 0, EV_IGNORED, 13'd0},
            '{1'b1, 40'd1200, 32'd1000, 32'd0, 0, EV_IGNORED, 13'd0},
            '{1'b1, 40'd1300, 32'd1000, 32'd700, 0, EV_IGNORED, 13'd0},
            '{1'b1, 40'd2400, 32'd1010, 32'd700, 0, EV_IGNORED, 13'd0},
            '{1'b1, 40'd5, 32'd0, 32'd0, 1, EV_RESTART, 13'd1},
            '{1'b0, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, EV_IGNORED, 13'd1},
            '{1'b1, 40'd10, 32'd1686629713, 32'd1686629713, 0, EV_IGNORED, 13'd0},
            '{1'b1, 40'd20, 32'd1686629713, 32'hD986_A1AF, 0, EV_IGNORED, 13'd0},
            '{1'b1, 40'd30, 32'hD986_A1AF, 32'hD986_A1AF, 0, EV_IGNORED, 13'd0},
            '{1'b1, 40'd40, 32'd843314856, 32'd1686629000, 0, EV_IGNORED, 13'd0},
            '{1'b1, 40'd50, 32'd843314856, 32'hD986_A4AF, 0, EV_IGNORED, 13'd0},
            '{1'b1, 40'd60, 32'd843400000, 32'd0, 0, EV_IGNORED, 13'd0},
            '{1'b1, 40'd70, 32'd1000000000, 32'd5000, 0, EV_IGNORED, 13'd0},
            '{1'b1, 40'd80, 32'h8000_0000, 32'h7FFF_FFFF, 0, EV_IGNORED, 13'd0},
            '{1'b1, 40'hFF_FFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, EV_IGNORED, 13'd0},
            '{1'b1, 40'hFF_FFFF_FFFF, 32'h7FFF_FFF0, 32'h8000_0000, 0, EV_IGNORED, 13'd0},
            '{1'b1, 40'd0, 32'd0, 32'd0, 1, EV_RESTART, 13'd1},
            '{1'b1, 40'd900, 32'd3, 32'd3, 0, EV_IGNORED, 13'd0},
            '{1'b1, 40'd2000, 32'd12, 32'd0, 0, EV_IGNORED, 13'd0}
        };
        foreach (rows[i])
            send_word(rows[i].ok, rows[i].t, rows[i].lat, rows[i].lon,
                      rows[i].typed, rows[i].ev, rows[i].count);
        in_valid <= 1'b0;
        drain();

        // random phases, extremes first
        walk_t = 0;
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: regv = '{31'd0, 31'd0, 31'd0, 31'd2000000000};
                1: regv = '{31'd1000000, 31'd1000000, 31'd1000000, 31'd0};
                2: regv = '{31'd500, 31'd10, 31'd1000, 31'd5000000};
                default:
                    regv = '{31'($urandom_range(0, 5000)), 31'($urandom_range(0, 500)),
                             31'($urandom_range(0, 3000)),
                             31'($urandom_range(1000, 20000000))};
            endcase
            for (int r = 0; r < 4; r++)
                write_reg(r[1:0], regv[r]);
            calm = (ph == 4);
            step_span = (ph % 2) ? 300 : 4000;
            walk_lat = longint'($urandom_range(0, 32'(TWO_PI_FX))) - PI_FX;
            walk_lon = longint'($urandom_range(0, 32'(TWO_PI_FX))) - PI_FX;
            for (int k = 0; k < 220; k++)
                walk_word();
            in_valid <= 1'b0;
            drain();
        end

        if (mismatches == 0 && exp_wr == exp_rd)
            $display("PASS track_point_decimator");
        else
            $display("FAIL track_point_decimator");
        $finish;
    end
endmodule
